/* src/ccfr_pkg.sv */
package ccfr_pkg;

  localparam int HDR_LEN = 20;
  localparam logic [7:0] MAGIC0 = 8'h55;
  localparam logic [7:0] MAGIC1 = 8'h41;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_COBS      = 3'd1,
    ST_SHORT     = 3'd2,
    ST_CRC       = 3'd3,
    ST_MAGIC     = 3'd4,
    ST_LENGTH    = 3'd5
  } frame_status_t;

  // One entry of the result queue: header fields are filled only on an ok verdict.
  typedef struct packed {
    logic        is_verdict;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [2:0]  frame_status;
    logic [7:0]  message_type;
    logic [15:0] message_flags;
    logic [15:0] payload_length;
    logic [31:0] session_id;
    logic [31:0] sequence_number;
    logic [31:0] sample_position;
    logic [31:0] error_total;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* src/ccfr_front.sv */
module ccfr_front #(
  parameter int MAX_PAYLOAD   = 256,
  parameter int RAW_LIMIT     = 278,
  parameter int ENCODED_LIMIT = 280
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       version,
  output logic             res_valid,
  output ccfr_pkg::result_t res
);
  import ccfr_pkg::*;

  localparam int EW = $clog2(ENCODED_LIMIT + 1);
  localparam int DW = $clog2(RAW_LIMIT + 1);

  logic [EW-1:0] encoded_count_r;
  logic [7:0]    group_left_r;
  logic          zero_pending_r;
  logic [DW-1:0] decoded_count_r;
  logic          decode_failed_r;
  logic [15:0]   tail_delay_r;
  logic [15:0]   crc_r;
  logic [7:0]    hdr_r [HDR_LEN];
  logic [31:0]   err_r;

  logic          is_data, is_delim, ovf, have, emit_byte, decode_store;
  logic [7:0]    d;
  logic [15:0]   supplied, plen;
  logic [DW:0]   want_len;
  frame_status_t status;
  result_t       res_nxt;

  assign is_delim = in_valid && (rx_byte == 8'd0);
  assign is_data  = in_valid && (rx_byte != 8'd0);
  assign ovf      = encoded_count_r >= EW'(ENCODED_LIMIT);
  assign have     = (group_left_r == 8'd0) ? zero_pending_r : 1'b1;
  assign d        = (group_left_r == 8'd0) ? 8'd0 : rx_byte;
  assign decode_store = is_data && !ovf && have && !decode_failed_r &&
                        (decoded_count_r < DW'(RAW_LIMIT));
  assign emit_byte = decode_store && (decoded_count_r >= DW'(HDR_LEN + 2));

  assign supplied = {tail_delay_r[7:0], tail_delay_r[15:8]};
  assign plen     = {hdr_r[7], hdr_r[6]};
  assign want_len = (DW+1)'(HDR_LEN + 2) + (DW+1)'(plen);

  always_comb begin
    if (decode_failed_r || group_left_r != 8'd0) status = ST_COBS;
    else if (decoded_count_r < DW'(HDR_LEN + 2)) status = ST_SHORT;
    else if (crc_r != supplied) status = ST_CRC;
    else if (hdr_r[0] != MAGIC0 || hdr_r[1] != MAGIC1 || hdr_r[2] != version)
      status = ST_MAGIC;
    else if (plen > 16'(MAX_PAYLOAD) || (DW+1)'(decoded_count_r) != want_len)
      status = ST_LENGTH;
    else status = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      encoded_count_r <= '0;
      group_left_r    <= '0;
      zero_pending_r  <= 1'b0;
      decoded_count_r <= '0;
      decode_failed_r <= 1'b0;
      tail_delay_r    <= '0;
      crc_r           <= CRC_INIT;
      err_r           <= '0;
      res_valid       <= 1'b0;
    end else begin
      if (is_data) begin
        if (ovf) begin
          err_r           <= err_r + 32'd1;
          encoded_count_r <= '0;
          group_left_r    <= '0;
          zero_pending_r  <= 1'b0;
          decoded_count_r <= '0;
          decode_failed_r <= 1'b0;
          tail_delay_r    <= '0;
          crc_r           <= CRC_INIT;
          res_valid       <= 1'b0;
        end else begin
          encoded_count_r <= encoded_count_r + EW'(1);
          if (group_left_r == 8'd0) begin
            group_left_r   <= rx_byte - 8'd1;
            zero_pending_r <= (rx_byte != 8'hFF);
          end else begin
            group_left_r <= group_left_r - 8'd1;
          end
          if (have && !decode_failed_r) begin
            if (decoded_count_r >= DW'(RAW_LIMIT)) begin
              decode_failed_r <= 1'b1;
            end else begin
              if (decoded_count_r >= DW'(2)) crc_r <= crc_byte(crc_r, tail_delay_r[15:8]);
              tail_delay_r    <= {tail_delay_r[7:0], d};
              decoded_count_r <= decoded_count_r + DW'(1);
            end
          end
          res_valid <= emit_byte;
        end
      end else if (is_delim && encoded_count_r != '0) begin
        if (status != ST_OK) err_r <= err_r + 32'd1;
        res_valid       <= 1'b1;
        encoded_count_r <= '0;
        group_left_r    <= '0;
        zero_pending_r  <= 1'b0;
        decoded_count_r <= '0;
        decode_failed_r <= 1'b0;
        tail_delay_r    <= '0;
        crc_r           <= CRC_INIT;
      end else begin
        res_valid <= 1'b0;
      end
    end
  end

  // Header bytes; never read before written on an ok verdict.
  always_ff @(posedge clk) begin
    if (decode_store && decoded_count_r < DW'(HDR_LEN))
      hdr_r[decoded_count_r[4:0]] <= d;
  end

  always_comb begin
    res_nxt = '0;
    if (emit_byte) begin
      res_nxt.data_byte  = tail_delay_r[15:8];
      res_nxt.byte_index = 8'(decoded_count_r - DW'(HDR_LEN + 2));
    end else begin
      res_nxt.is_verdict   = 1'b1;
      res_nxt.frame_status = status;
      res_nxt.error_total  = err_r + ((status != ST_OK) ? 32'd1 : 32'd0);
      if (status == ST_OK) begin
        res_nxt.message_type    = hdr_r[3];
        res_nxt.message_flags   = {hdr_r[5], hdr_r[4]};
        res_nxt.payload_length  = plen;
        res_nxt.session_id      = {hdr_r[11], hdr_r[10], hdr_r[9], hdr_r[8]};
        res_nxt.sequence_number = {hdr_r[15], hdr_r[14], hdr_r[13], hdr_r[12]};
        res_nxt.sample_position = {hdr_r[19], hdr_r[18], hdr_r[17], hdr_r[16]};
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_nxt;
  end

endmodule

/* src/ccfr_queue.sv */
module ccfr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  ccfr_pkg::result_t wr_data,
  output logic              almost_full,
  input  logic              rd_en,
  output logic              empty,
  output ccfr_pkg::result_t rd_data
);
  import ccfr_pkg::*;

  // Four entries: one in flight in the front register plus margin.
  result_t    mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign empty       = (cnt_r == 3'd0);
  assign almost_full = (cnt_r >= 3'd3);
  assign rd_data     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, wr_en} - {2'b0, rd_en};
    end
  end

endmodule

/* src/cobs_crc_frame_receiver.sv */
// COBS frame receiver with CRC-16/CCITT-FALSE check.
// Input channel: push one received byte (in_rx_byte) when full is low; a zero
//   byte ends a frame. One byte can be taken every cycle while full is low.
// Result channel: while empty is low, the out_ ports show the oldest result;
//   pop takes it. Payload bytes (out_is_verdict low) come out cut-through with
//   their index, delayed two decoded bytes so the CRC tail is never shown.
//   A delimiter after a non-empty frame gives one verdict with status, the
//   error total and, on status 0, the header fields. Drop the payload when
//   the status is not 0.
// Timing: the front stage registers each result and the queue stores it; it
//   shows on the out_ ports when it is the oldest entry. One byte per cycle is
//   taken while full is low, set by the decode and CRC step in the front stage.
// Configuration: cfg_we with cfg_data writes the expected version; write
//   only while idle. Reset value of the version is 1.
// Reset (rst_n low, synchronous): clear frame state, error counter and queue.
// Stall: when pop stays low the queue fills and full rises; it rises early
//   enough that the result in the front stage always finds room.
module cobs_crc_frame_receiver #(
  parameter int MAX_PAYLOAD   = 256,
  parameter int RAW_LIMIT     = 278,
  parameter int ENCODED_LIMIT = 280
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic        out_is_verdict,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_byte_index,
  output logic [2:0]  out_frame_status,
  output logic [7:0]  out_message_type,
  output logic [15:0] out_message_flags,
  output logic [15:0] out_payload_length,
  output logic [31:0] out_session_id,
  output logic [31:0] out_sequence_number,
  output logic [31:0] out_sample_position,
  output logic [31:0] out_error_total,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data
);
  import ccfr_pkg::*;

  logic [7:0] version_r;
  logic       res_valid, q_almost_full;
  result_t    res, head;

  always_ff @(posedge clk) begin
    if (!rst_n) version_r <= 8'd1;
    else if (cfg_we) version_r <= cfg_data;
  end

  // Hold input while the queue cannot absorb the request in flight.
  assign full = q_almost_full;

  ccfr_front #(
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .RAW_LIMIT    (RAW_LIMIT),
    .ENCODED_LIMIT(ENCODED_LIMIT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (push && !full),
    .rx_byte  (in_rx_byte),
    .version  (version_r),
    .res_valid(res_valid),
    .res      (res)
  );

  ccfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (res_valid),
    .wr_data    (res),
    .almost_full(q_almost_full),
    .rd_en      (pop && !empty),
    .empty      (empty),
    .rd_data    (head)
  );

  assign out_is_verdict      = head.is_verdict;
  assign out_data_byte       = head.data_byte;
  assign out_byte_index      = head.byte_index;
  assign out_frame_status    = head.frame_status;
  assign out_message_type    = head.message_type;
  assign out_message_flags   = head.message_flags;
  assign out_payload_length  = head.payload_length;
  assign out_session_id      = head.session_id;
  assign out_sequence_number = head.sequence_number;
  assign out_sample_position = head.sample_position;
  assign out_error_total     = head.error_total;

endmodule

/* src/ccfr_checker.sv */
module ccfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       out_is_verdict,
  input logic [7:0] out_data_byte,
  input logic [2:0] out_frame_status
);
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("queue not empty after reset");
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("full after reset");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_is_verdict |-> out_frame_status <= 3'd5)
    else $error("status out of range");
  a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_is_verdict |-> out_frame_status == 3'd0)
    else $error("payload byte with status");
  a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_data_byte))
    else $error("head changed while stalled");
endmodule

bind cobs_crc_frame_receiver ccfr_checker u_ccfr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .out_is_verdict  (out_is_verdict),
  .out_data_byte   (out_data_byte),
  .out_frame_status(out_frame_status)
);
